// ===== rtl/psr_pkg.sv =====
// ----------------------------------------------------------------------------
// psr_pkg
// Shared types, constants and the CRC step for the PSI section reassembler.
// ----------------------------------------------------------------------------
package psr_pkg;

    localparam int MAX_SECTION_BYTES = 4098;
    localparam int QUEUE_DEPTH       = 4;
    localparam int QUEUE_PTR_W       = $clog2(QUEUE_DEPTH);

    localparam logic [31:0] CRC_POLY     = 32'h04C1_1DB7;
    localparam logic [31:0] CRC_INIT     = 32'hFFFF_FFFF;
    localparam logic [7:0]  STUFF_BYTE   = 8'hFF;
    localparam logic [7:0]  SYNTAX_MASK  = 8'h80;
    localparam logic [7:0]  LEN_HI_MASK  = 8'h0F;

    localparam logic [0:0]  REG_POINTER_MODE = 1'b0;
    localparam logic [0:0]  REG_MAX_LENGTH   = 1'b1;

    typedef enum logic [1:0] {
        ST_NONE    = 2'd0,
        ST_GOOD    = 2'd1,
        ST_CRC_ERR = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // packet position of a byte, resolved at the front
    typedef enum logic [1:0] {
        K_CONT     = 2'd0,
        K_NEW_PKT  = 2'd1,
        K_START    = 2'd2,
        K_POINTER  = 2'd3
    } t_kind;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_HUNT     = 3'd1,
        PH_STUFF    = 3'd2,
        PH_PTR      = 3'd3,
        PH_PTR_OPEN = 3'd4,
        PH_SEC      = 3'd5
    } t_phase;

    typedef struct packed {
        logic [7:0] data_byte;
        t_kind      kind;
        logic       last;
    } t_item;

    typedef struct packed {
        logic [7:0]  byte_out;
        logic        in_section;
        logic        section_first;
        t_status     status;
        logic [7:0]  tbl_id;
        logic [12:0] section_bytes;
        logic [31:0] crc_field;
    } t_result;

    function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
        logic [31:0] c;
        c = crc ^ {b, 24'd0};
        for (int i = 0; i < 8; i++) begin
            if (c[31]) begin
                c = {c[30:0], 1'b0} ^ CRC_POLY;
            end else begin
                c = {c[30:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ===== rtl/psr_in_if.sv =====
// ----------------------------------------------------------------------------
// psr_in_if
// Payload byte channel into the reassembler.
// ----------------------------------------------------------------------------
interface psr_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       first_of_packet;
    logic       last_of_packet;
    logic       unit_start;

    modport source (
        output valid, data_byte, first_of_packet, last_of_packet, unit_start,
        input  ready
    );
    modport sink (
        input  valid, data_byte, first_of_packet, last_of_packet, unit_start,
        output ready
    );
endinterface

// ===== rtl/psr_out_if.sv =====
// ----------------------------------------------------------------------------
// psr_out_if
// Per-byte result channel out of the reassembler.
// ----------------------------------------------------------------------------
interface psr_out_if;
    logic        valid;
    logic        ready;
    logic [7:0]  byte_out;
    logic        in_section;
    logic        section_first;
    logic [1:0]  status;
    logic [7:0]  tbl_id;
    logic [12:0] section_bytes;
    logic [31:0] crc_field;

    modport source (
        output valid, byte_out, in_section, section_first, status, tbl_id,
               section_bytes, crc_field,
        input  ready
    );
    modport sink (
        input  valid, byte_out, in_section, section_first, status, tbl_id,
               section_bytes, crc_field,
        output ready
    );
endinterface

// ===== rtl/psr_front.sv =====
// ----------------------------------------------------------------------------
// psr_front
// Accepts payload bytes and tags each with its packet position.
// ----------------------------------------------------------------------------
module psr_front
    import psr_pkg::*;
(
    input  logic       i_valid,
    input  logic [7:0] i_data_byte,
    input  logic       i_first_of_packet,
    input  logic       i_last_of_packet,
    input  logic       i_unit_start,
    input  logic       i_pointer_mode,
    input  logic       i_queue_full,
    output logic       o_ready,
    output logic       o_push,
    output t_item      o_item
);

    t_kind w_kind;

    always_comb begin
        if (i_first_of_packet && i_unit_start) begin
            w_kind = i_pointer_mode ? K_POINTER : K_START;
        end else if (i_first_of_packet) begin
            w_kind = K_NEW_PKT;
        end else begin
            w_kind = K_CONT;
        end
    end

    assign o_ready          = !i_queue_full;
    assign o_push           = i_valid && !i_queue_full;
    assign o_item.data_byte = i_data_byte;
    assign o_item.kind      = w_kind;
    assign o_item.last      = i_last_of_packet;

endmodule

// ===== rtl/psr_queue.sv =====
// ----------------------------------------------------------------------------
// psr_queue
// Short queue of tagged bytes between the front and the section engine.
// ----------------------------------------------------------------------------
module psr_queue
    import psr_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_item i_item,
    output logic  o_full,
    input  logic  i_pop,
    output logic  o_valid,
    output t_item o_item
);

    t_item                  r_mem [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] r_wr_ptr;
    logic [QUEUE_PTR_W-1:0] r_rd_ptr;
    logic [QUEUE_PTR_W:0]   r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    assign o_full  = (r_count == (QUEUE_PTR_W+1)'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rd_ptr];

endmodule

// ===== rtl/psr_back.sv =====
// ----------------------------------------------------------------------------
// psr_back
// Section engine: phase tracking, length check, CRC-32 and the result register.
// ----------------------------------------------------------------------------
module psr_back
    import psr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_item       i_item,
    output logic        o_pop,
    input  logic [11:0] i_max_length,
    output logic        o_valid,
    input  logic        i_ready,
    output t_result     o_result
);

    localparam logic [12:0] MAX_BYTES = 13'(MAX_SECTION_BYTES);

    t_phase      r_phase;
    logic [7:0]  r_pointer_left;
    logic [12:0] r_byte_count;
    logic [12:0] r_total_count;
    logic [31:0] r_crc;
    logic [7:0]  r_tbl_id;
    logic [7:0]  r_length_high;
    logic [31:0] r_tail;
    logic        r_out_valid;
    t_result     r_out;

    t_phase      n_phase;
    logic [7:0]  n_pointer_left;
    logic [12:0] n_byte_count;
    logic [12:0] n_total_count;
    logic [31:0] n_crc;
    logic [7:0]  n_tbl_id;
    logic [7:0]  n_length_high;
    logic [31:0] n_tail;
    t_result     n_out;

    // shared decode of the current byte
    t_phase      w_ph_pkt;
    t_phase      w_ph_work;
    logic        w_feed;
    logic        w_in_ptr;
    logic        w_first;
    logic [12:0] w_bc;
    logic [12:0] w_bc_next;
    logic [11:0] w_len;
    logic [12:0] w_total_in;
    logic [12:0] w_len_plus3;
    logic        w_bad_hdr;
    logic [31:0] w_crc_in;
    logic [31:0] w_crc_new;
    t_status     w_status;
    logic [7:0]  w_ptr_dec;
    logic [7:0]  b;

    assign o_pop = i_valid && (!r_out_valid || i_ready);
    assign b     = i_item.data_byte;

    always_comb begin
        w_ph_pkt = r_phase;
        if (i_item.kind == K_START) begin
            w_ph_pkt = PH_HUNT;
        end else if (i_item.kind == K_NEW_PKT && r_phase inside {PH_HUNT, PH_STUFF,
                                                                  PH_PTR, PH_PTR_OPEN}) begin
            w_ph_pkt = PH_IDLE;
        end

        w_ph_work = w_ph_pkt;
        if (w_ph_pkt == PH_HUNT) begin
            w_ph_work = (b == STUFF_BYTE) ? PH_STUFF : PH_SEC;
        end

        w_feed   = (i_item.kind != K_POINTER) &&
                   (w_ph_work == PH_SEC || w_ph_work == PH_PTR_OPEN);
        w_in_ptr = (w_ph_work == PH_PTR_OPEN);

        // a section opened from hunting restarts the byte count
        w_bc        = (w_ph_pkt == PH_HUNT) ? 13'd0 : r_byte_count;
        w_first     = (w_bc == 13'd0);
        w_bc_next   = w_bc + 13'd1;
        w_crc_in    = w_first ? CRC_INIT : r_crc;
        w_crc_new   = crc_byte(w_crc_in, b);
        w_total_in  = w_first ? 13'd0 : r_total_count;
        w_len       = {r_length_high[3:0], b};
        w_len_plus3 = {1'b0, w_len} + 13'd3;
        w_bad_hdr   = ((r_length_high & SYNTAX_MASK) == 8'd0) || (w_len == 12'd0) ||
                      (w_len > i_max_length) || (w_len_plus3 > MAX_BYTES);

        w_status = ST_NONE;
        if (w_bc_next == 13'd3 && w_bad_hdr) begin
            w_status = ST_INVALID;
        end else if (w_bc_next >= 13'd3 &&
                     w_bc_next == ((w_bc_next == 13'd3) ? w_len_plus3 : w_total_in)) begin
            w_status = (w_crc_new == 32'd0) ? ST_GOOD : ST_CRC_ERR;
        end

        w_ptr_dec = r_pointer_left - 8'd1;
    end

    // next phase
    always_comb begin
        n_phase = r_phase;
        if (i_item.kind == K_POINTER) begin
            if (b == 8'd0) begin
                n_phase = PH_HUNT;
            end else if (r_phase == PH_SEC) begin
                n_phase = PH_PTR_OPEN;
            end else begin
                n_phase = PH_PTR;
            end
        end else begin
            n_phase = w_ph_work;
            if (w_feed) begin
                if (w_status == ST_INVALID) begin
                    n_phase = w_in_ptr ? PH_PTR : PH_IDLE;
                end else if (w_status != ST_NONE) begin
                    n_phase = w_in_ptr ? PH_PTR : PH_HUNT;
                end
                if (w_in_ptr && w_ptr_dec == 8'd0) begin
                    n_phase = PH_HUNT;
                end
            end else if (w_ph_work == PH_PTR && w_ptr_dec == 8'd0) begin
                n_phase = PH_HUNT;
            end
        end
        if (i_item.last && n_phase != PH_SEC) begin
            n_phase = PH_IDLE;
        end
    end

    // section state and result
    always_comb begin
        n_pointer_left = r_pointer_left;
        n_byte_count   = r_byte_count;
        n_total_count  = r_total_count;
        n_crc          = r_crc;
        n_tbl_id       = r_tbl_id;
        n_length_high  = r_length_high;
        n_tail         = r_tail;

        if (i_item.kind == K_POINTER) begin
            n_pointer_left = b;
        end else if (w_feed) begin
            n_byte_count = w_bc_next;
            n_crc        = w_crc_new;
            n_tail       = w_first ? {24'd0, b} : {r_tail[23:0], b};
            n_tbl_id     = w_first ? b : r_tbl_id;
            n_total_count = w_total_in;
            if (w_bc_next == 13'd2) begin
                n_length_high = b;
            end
            if (w_bc_next == 13'd3 && !w_bad_hdr) begin
                n_total_count = w_len_plus3;
            end
            if (w_in_ptr) begin
                n_pointer_left = w_ptr_dec;
            end
        end else if (w_ph_work == PH_PTR) begin
            n_pointer_left = w_ptr_dec;
        end

        n_out.byte_out      = b;
        n_out.in_section    = w_feed;
        n_out.section_first = w_feed && w_first;
        n_out.status        = w_feed ? w_status : ST_NONE;
        if (w_feed && (w_status == ST_GOOD || w_status == ST_CRC_ERR)) begin
            n_out.tbl_id        = n_tbl_id;
            n_out.section_bytes = n_total_count;
            n_out.crc_field     = n_tail;
        end else begin
            n_out.tbl_id        = 8'd0;
            n_out.section_bytes = 13'd0;
            n_out.crc_field     = 32'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_IDLE;
            r_pointer_left <= 8'd0;
            r_byte_count   <= 13'd0;
            r_total_count  <= 13'd0;
            r_crc          <= CRC_INIT;
            r_tbl_id       <= 8'hFF;
            r_length_high  <= 8'd0;
            r_tail         <= 32'd0;
            r_out_valid    <= 1'b0;
        end else begin
            if (o_pop) begin
                r_phase        <= n_phase;
                r_pointer_left <= n_pointer_left;
                r_byte_count   <= n_byte_count;
                r_total_count  <= n_total_count;
                r_crc          <= n_crc;
                r_tbl_id       <= n_tbl_id;
                r_length_high  <= n_length_high;
                r_tail         <= n_tail;
                r_out_valid    <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_out <= n_out;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ===== rtl/psi_section_reassembler.sv =====
// ----------------------------------------------------------------------------
// psi_section_reassembler
// PSI section reassembly from transport payload bytes with CRC-32 check.
// ----------------------------------------------------------------------------
// Takes one payload byte per clock while the queue is not full and returns
// one result per byte, in order. A byte is tagged at the input and placed
// in a four-entry queue; the section engine takes one byte per clock from it
// unless the output stalls, and registers its result. The combinational
// CRC-32 byte step in the section engine sets the one-byte-per-clock rate.
// Output stalls are absorbed by the queue; input ready drops only when the
// queue is full. The user must write configuration (pointer mode, maximum
// section length) through the write port while idle; it is not enforced.
module psi_section_reassembler
    import psr_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [0:0]  i_cfg_index,
    input  logic [11:0] i_cfg_data,
    psr_in_if.sink      i_item,
    psr_out_if.source   o_result
);

    logic        r_pointer_mode;
    logic [11:0] r_max_length;

    logic        w_push;
    logic        w_full;
    logic        w_pop;
    logic        w_q_valid;
    t_item       w_front_item;
    t_item       w_q_item;
    t_result     w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pointer_mode <= 1'b1;
            r_max_length   <= 12'hFFF;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                REG_POINTER_MODE: r_pointer_mode <= i_cfg_data[0];
                REG_MAX_LENGTH:   r_max_length   <= i_cfg_data;
                default:          r_max_length   <= r_max_length;
            endcase
        end
    end

    psr_front u_front (
        .i_valid           (i_item.valid),
        .i_data_byte       (i_item.data_byte),
        .i_first_of_packet (i_item.first_of_packet),
        .i_last_of_packet  (i_item.last_of_packet),
        .i_unit_start      (i_item.unit_start),
        .i_pointer_mode    (r_pointer_mode),
        .i_queue_full      (w_full),
        .o_ready           (i_item.ready),
        .o_push            (w_push),
        .o_item            (w_front_item)
    );

    psr_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_item  (w_front_item),
        .o_full  (w_full),
        .i_pop   (w_pop),
        .o_valid (w_q_valid),
        .o_item  (w_q_item)
    );

    psr_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_item       (w_q_item),
        .o_pop        (w_pop),
        .i_max_length (r_max_length),
        .o_valid      (o_result.valid),
        .i_ready      (o_result.ready),
        .o_result     (w_result)
    );

    assign o_result.byte_out      = w_result.byte_out;
    assign o_result.in_section    = w_result.in_section;
    assign o_result.section_first = w_result.section_first;
    assign o_result.status        = w_result.status;
    assign o_result.tbl_id        = w_result.tbl_id;
    assign o_result.section_bytes = w_result.section_bytes;
    assign o_result.crc_field     = w_result.crc_field;

`ifndef SYNTHESIS
    // the engine never takes a byte from an empty queue
    a_pop_needs_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_pop |-> w_q_valid)
        else $error("section engine popped an empty queue");

    // a completed section is reported on a byte inside that section
    a_done_in_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && (o_result.status == ST_GOOD || o_result.status == ST_CRC_ERR))
        |-> o_result.in_section)
        else $error("completion status on a byte outside a section");

    // summary fields stay zero unless a section completed
    a_summary_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.status != ST_GOOD && o_result.status != ST_CRC_ERR)
        |-> (o_result.tbl_id == 8'd0 && o_result.section_bytes == 13'd0 &&
             o_result.crc_field == 32'd0))
        else $error("section summary set without completion");

    // table id byte is always counted in the section
    a_first_in_section: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result.valid && o_result.section_first) |-> o_result.in_section)
        else $error("section start flagged outside a section");
`endif

endmodule
